>>> rtl/knuth_yao_gaussian_sampler_assert.svh
// ----------------------------------------------------------------------------
// Knuth-Yao sampler assertion macros
// Shared property shapes for the sampler's internal checks.
// ----------------------------------------------------------------------------
`ifndef KNUTH_YAO_GAUSSIAN_SAMPLER_ASSERT_SVH
`define KNUTH_YAO_GAUSSIAN_SAMPLER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define KYGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define KYGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/kygs_pkg.sv
// ----------------------------------------------------------------------------
// kygs_pkg
// Types and constants of the Knuth-Yao Gaussian sampler pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kygs_pkg;

    localparam int ROWS_PER_STAGE = 2;
    localparam int COLS_PER_STAGE = 8;
    localparam int DATA_W         = 128;
    localparam int BITS_W         = 40;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [3:0]  TAIL_CUT_RESET = 4'd13;
    localparam logic [4:0]  SIGMA_RESET    = 5'd3;
    localparam logic [10:0] CENTER_RESET   = 11'd0;

    typedef enum logic [1:0] {
        REG_TAIL_CUT = 2'd0,
        REG_SIGMA    = 2'd1,
        REG_CENTER   = 2'd2
    } t_reg_index;

    // Row scan slot; a load carries its row data in the random field
    typedef struct packed {
        logic                valid;
        logic                cmd;
        logic                sign;
        logic [DATA_W-1:0]   data;
        logic [31:0]         distance;
        logic                hit;
        logic [6:0]          kept;
        logic [6:0]          row_sel;
    } t_row_slot;

    // Column scan slot
    typedef struct packed {
        logic                valid;
        logic                sign;
        logic [7:0]          rem;
        logic                hit;
        logic [5:0]          col;
        logic [BITS_W-1:0]   bits;
    } t_col_slot;

    // Modulo reduction slot
    typedef struct packed {
        logic                valid;
        logic                sign;
        logic [5:0]          rem;
    } t_mod_slot;

    // One row of the distance walk
    function automatic t_row_slot row_step(t_row_slot s, logic [6:0] w, logic b,
                                           logic [6:0] row);
        logic [31:0] d;
        d = {s.distance[30:0], b};
        if (!s.hit && (d < {25'd0, w})) begin
            s.kept     = d[6:0];
            s.row_sel  = row;
            s.hit      = 1'b1;
            s.distance = d;
        end else begin
            s.distance = d - {25'd0, w};
        end
        return s;
    endfunction

    // One column of the distance countdown
    function automatic t_col_slot col_step(t_col_slot s, logic b, logic [5:0] col);
        if (!s.hit && b) begin
            s.rem = s.rem - 8'd1;
            if (s.rem == 8'd0) begin
                s.hit = 1'b1;
                s.col = col;
            end
        end
        return s;
    endfunction

    // One restoring step of the column reduction
    function automatic logic [5:0] mod_step(logic [5:0] rem, logic [8:0] m, int unsigned k);
        logic [15:0] t;
        t = {7'd0, m} << k;
        if ({10'd0, rem} >= t) begin
            rem = rem - t[5:0];
        end
        return rem;
    endfunction

endpackage

>>> rtl/knuth_yao_gaussian_sampler.sv
// ----------------------------------------------------------------------------
// knuth_yao_gaussian_sampler
// Pipelined Knuth-Yao discrete Gaussian sampler over a loaded table.
// ----------------------------------------------------------------------------
// Use: the request channel (i_valid / o_ready) takes two kinds of request.
// A load (command 0) writes one table row: weight, high and low column bits.
// A sample (command 1) brings 128 random bits and a sign bit and yields one
// 12-bit signed sample on the result channel (o_valid / i_ready); a load
// yields nothing. Loads travel the pipeline in order, so a sample sees
// exactly the loads accepted before it.
// Path: from acceptance a request passes the row scan of two rows per
// stage, the memory read, eight columns per stage and a two-stage modulo
// unit before o_valid. Throughput: one request per cycle while the
// pipeline is not stalled.
// Stall: when a result waits and i_ready is low, the whole pipeline holds
// and o_ready drops; nothing is lost or repeated.
// Reset: i_rst_n low clears all valid bits and sets tail_cut 13, sigma 3,
// center 0. Table contents are undefined until loaded.
// Registers on the APB port: tail_cut at 0x0, sigma at 0x4, center at 0x8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "knuth_yao_gaussian_sampler_assert.svh"

module knuth_yao_gaussian_sampler
    import kygs_pkg::*;
#(
    parameter int ROW_COUNT    = 128,
    parameter int COLUMN_COUNT = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [6:0]         i_row_index,
    input  logic [6:0]         i_row_weight,
    input  logic [31:0]        i_row_high_bits,
    input  logic [7:0]         i_row_low_bits,
    input  logic [63:0]        i_random_low,
    input  logic [63:0]        i_random_high,
    input  logic               i_sign_bit,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [11:0] o_sample,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NRS    = (ROW_COUNT + ROWS_PER_STAGE - 1) / ROWS_PER_STAGE;
    localparam int NCS    = (COLUMN_COUNT + COLS_PER_STAGE - 1) / COLS_PER_STAGE;
    localparam int ROW_IW = $clog2(ROW_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  r_tail_cut;
    logic [4:0]  r_sigma;
    logic [10:0] r_center;
    logic        c_cfg_wr;
    logic [8:0]  c_bound;
    logic [8:0]  c_modulus;

    assign pready   = 1'b1;
    assign c_cfg_wr = psel && penable && pwrite;

    // write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_cut <= TAIL_CUT_RESET;
            r_sigma    <= SIGMA_RESET;
            r_center   <= CENTER_RESET;
        end else if (c_cfg_wr) begin
            unique case (t_reg_index'(paddr[3:2]))
                REG_TAIL_CUT: r_tail_cut <= pwdata[3:0];
                REG_SIGMA:    r_sigma    <= pwdata[4:0];
                REG_CENTER:   r_center   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (t_reg_index'(paddr[3:2]))
            REG_TAIL_CUT: prdata = {28'd0, r_tail_cut};
            REG_SIGMA:    prdata = {27'd0, r_sigma};
            REG_CENTER:   prdata = {21'd0, r_center};
            default:      prdata = 32'd0;
        endcase
    end

    assign c_bound   = {5'd0, r_tail_cut} * {4'd0, r_sigma};
    assign c_modulus = c_bound + 9'd1;

    // ------------------------------------------------------------------
    // Pipeline enable: hold everything while a result waits
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic en;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // ------------------------------------------------------------------
    // Row scan stages
    // ------------------------------------------------------------------
    t_row_slot r_rs [NRS+1];
    t_row_slot c_rs_next [NRS];
    t_row_slot c_chain [NRS][ROWS_PER_STAGE+1];
    t_row_slot c_in_slot;
    logic [6:0] r_weight [1:ROW_COUNT-1];

    // pack the request
    always_comb begin
        c_in_slot         = '0;
        c_in_slot.valid   = i_valid;
        c_in_slot.cmd     = i_command;
        c_in_slot.sign    = i_sign_bit;
        if (i_command == CMD_LOAD) begin
            c_in_slot.data = {74'd0, i_row_high_bits, i_row_low_bits, i_row_weight,
                              i_row_index};
        end else begin
            c_in_slot.data = {i_random_high, i_random_low};
        end
    end

    for (genvar gk = 0; gk < NRS; gk++) begin : g_row_stage
        assign c_chain[gk][0] = r_rs[gk];
        for (genvar gi = 0; gi < ROWS_PER_STAGE; gi++) begin : g_row
            localparam int ROW = gk * ROWS_PER_STAGE + gi;
            if (ROW >= 1 && ROW < ROW_COUNT) begin : g_live
                // walk one row
                assign c_chain[gk][gi+1] = row_step(c_chain[gk][gi], r_weight[ROW],
                                                    c_chain[gk][gi].data[ROW], 7'(ROW));
                // a load passing this stage writes its row's weight
                always_ff @(posedge i_clk) begin
                    if (en && r_rs[gk].valid && (r_rs[gk].cmd == CMD_LOAD)
                            && (r_rs[gk].data[6:0] == 7'(ROW))) begin
                        r_weight[ROW] <= r_rs[gk].data[13:7];
                    end
                end
            end else begin : g_idle
                assign c_chain[gk][gi+1] = c_chain[gk][gi];
            end
        end
        assign c_rs_next[gk] = c_chain[gk][ROWS_PER_STAGE];
    end

    // advance the row pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NRS; k++) begin
                r_rs[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_rs[0] <= c_in_slot;
            for (int k = 0; k < NRS; k++) begin
                r_rs[k+1] <= c_rs_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Column bit memory: written by loads, read at the kept row
    // ------------------------------------------------------------------
    logic [BITS_W-1:0] r_bits_mem [ROW_COUNT];
    logic [BITS_W-1:0] r_bits_q;
    t_row_slot         c_last;
    logic              c_load_ok;

    assign c_last    = r_rs[NRS];
    assign c_load_ok = ({1'b0, c_last.data[6:0]} < 8'(ROW_COUNT));

    always_ff @(posedge i_clk) begin
        if (en && c_last.valid) begin
            if (c_last.cmd == CMD_LOAD) begin
                if (c_load_ok) begin
                    r_bits_mem[c_last.data[ROW_IW-1:0]] <= c_last.data[53:14];
                end
            end else begin
                r_bits_q <= r_bits_mem[c_last.row_sel[ROW_IW-1:0]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Column scan stages
    // ------------------------------------------------------------------
    t_col_slot r_cs [NCS+1];
    t_col_slot c_cs_head;
    t_col_slot c_cs_next [NCS];
    t_col_slot c_cc [NCS][COLS_PER_STAGE+1];
    t_col_slot c_cs_in;

    // drop loads here; a sample counts down kept+1 ones
    always_comb begin
        c_cs_in       = '0;
        c_cs_in.valid = c_last.valid && (c_last.cmd == CMD_SAMPLE);
        c_cs_in.sign  = c_last.sign;
        c_cs_in.rem   = {1'b0, c_last.kept} + 8'd1;
    end

    always_comb begin
        c_cs_head      = r_cs[0];
        c_cs_head.bits = r_bits_q;
    end

    for (genvar gj = 0; gj < NCS; gj++) begin : g_col_stage
        if (gj == 0) begin : g_head
            assign c_cc[gj][0] = c_cs_head;
        end else begin : g_body
            assign c_cc[gj][0] = r_cs[gj];
        end
        for (genvar gc = 0; gc < COLS_PER_STAGE; gc++) begin : g_col
            localparam int COL = gj * COLS_PER_STAGE + gc;
            localparam int BIT = (COL < 32) ? (BITS_W - 1 - COL) : (COLUMN_COUNT - 1 - COL);
            if (COL < COLUMN_COUNT) begin : g_live
                assign c_cc[gj][gc+1] = col_step(c_cc[gj][gc], c_cc[gj][gc].bits[BIT],
                                                 6'(COL));
            end else begin : g_idle
                assign c_cc[gj][gc+1] = c_cc[gj][gc];
            end
        end
        assign c_cs_next[gj] = c_cc[gj][COLS_PER_STAGE];
    end

    // advance the column pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NCS; j++) begin
                r_cs[j].valid <= 1'b0;
            end
        end else if (en) begin
            r_cs[0] <= c_cs_in;
            for (int j = 0; j < NCS; j++) begin
                r_cs[j+1] <= c_cs_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Column modulo (bound + 1): restoring steps, three per stage
    // ------------------------------------------------------------------
    t_mod_slot r_ma;
    t_mod_slot r_mb;
    t_mod_slot c_ma;
    t_mod_slot c_mb;
    t_col_slot c_cs_tail;

    assign c_cs_tail = r_cs[NCS];

    always_comb begin
        c_ma.valid = c_cs_tail.valid;
        c_ma.sign  = c_cs_tail.sign;
        c_ma.rem   = c_cs_tail.hit ? c_cs_tail.col : 6'd0;
        c_ma.rem   = mod_step(c_ma.rem, c_modulus, 5);
        c_ma.rem   = mod_step(c_ma.rem, c_modulus, 4);
        c_ma.rem   = mod_step(c_ma.rem, c_modulus, 3);
    end

    always_comb begin
        c_mb     = r_ma;
        c_mb.rem = mod_step(c_mb.rem, c_modulus, 2);
        c_mb.rem = mod_step(c_mb.rem, c_modulus, 1);
        c_mb.rem = mod_step(c_mb.rem, c_modulus, 0);
    end

    // ------------------------------------------------------------------
    // Offset, sign and output register
    // ------------------------------------------------------------------
    logic [11:0] c_offset;
    logic [11:0] c_result;
    logic [11:0] r_out_sample;

    assign c_offset = {6'd0, r_mb.rem} - {3'd0, c_bound} + {r_center[10], r_center};
    assign c_result = r_mb.sign ? (12'd0 - c_offset) : c_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma.valid  <= 1'b0;
            r_mb.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_ma         <= c_ma;
            r_mb         <= c_mb;
            r_out_valid  <= r_mb.valid;
            r_out_sample <= c_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `KYGS_ASSERT_NOW(a_mod_in_range, r_mb.valid, {3'd0, r_mb.rem} < c_modulus, "column not reduced below modulus")
    `KYGS_ASSERT_NEXT(a_load_dropped, en && c_last.valid && (c_last.cmd == CMD_LOAD), !r_cs[0].valid, "load reached column scan")
    `KYGS_ASSERT_NEXT(a_stall_holds, !en, $stable(r_mb.valid) && $stable(r_ma.valid), "pipeline moved during stall")
    `KYGS_ASSERT_NOW(a_count_nonzero, r_cs[0].valid, r_cs[0].rem != 8'd0, "column countdown starts at zero")

endmodule
